@@ rtl/wvhc_pkg.sv @@
// wvhc_pkg: payload types and fixed constants of the word verdict hash cache.
// No dependencies; used by word_verdict_hash_cache.
package wvhc_pkg;

    localparam logic [1:0] KIND_LOOKUP = 2'd0;
    localparam logic [1:0] KIND_PUT    = 2'd1;
    localparam logic [1:0] KIND_CLEAR  = 2'd2;
    localparam logic [1:0] KIND_RSVD   = 2'd3;

    localparam logic [31:0] HASH_START = 32'd5381;
    localparam int          CP_W       = 21;

    typedef struct packed {
        logic [1:0]      kind;
        logic [CP_W-1:0] code_point;
        logic            last;
        logic            verdict_in;
    } t_in;

    typedef struct packed {
        logic hit;
        logic verdict_out;
        logic too_long;
    } t_out;

endpackage

@@ rtl/word_verdict_hash_cache.sv @@
// word_verdict_hash_cache: open-addressed word-to-verdict cache, djb2 hash, linear probing.
// Depends on wvhc_pkg (payload types, kind codes, hash start).
//
// A character beat that is not the end of a word only updates the hash and the stored word.
// The end-of-word beat moves through ST_MODQ and ST_MODR, which turn the hash into the home
// slot, then the block walks the probe sequence: each probed slot reads its header in ST_HRD
// and ST_HCHK, and a slot whose length matches compares each character in ST_CRD and ST_CCHK,
// all through the single read port of the character memory. A put that writes a new entry
// copies the word in ST_WRITE. A too-long end beat gives its result straight from idle. A
// clear beat runs a sweep over the header memory in ST_CLR; after reset the same sweep runs
// once before the first beat is taken. Results go into a two-entry output buffer; input beats
// stall while the block is not idle or while the second entry is full.
module word_verdict_hash_cache #(
    parameter int SLOTS   = 64,
    parameter int MAX_LEN = 255
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  wvhc_pkg::t_in   i_data,
    output logic            o_valid,
    input  logic            i_ready,
    output wvhc_pkg::t_out  o_data
);
    localparam int SW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int LW   = $clog2(MAX_LEN + 2);        // holds MAX_LEN+1
    localparam int CW   = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int CD   = SLOTS * MAX_LEN;
    localparam int AW   = $clog2(CD);
    localparam int HW   = 2 + LW;                      // valid, verdict, length

    // reciprocal of SLOTS; the quotient estimate is low by at most one
    localparam logic [63:0] RECIP_W = (64'd1 << (32 + SW)) / 64'(SLOTS);
    localparam logic [32:0] RECIP   = RECIP_W[32:0];

    localparam logic [3:0] ST_CLR   = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_HRD   = 4'd2;
    localparam logic [3:0] ST_HCHK  = 4'd3;
    localparam logic [3:0] ST_CRD   = 4'd4;
    localparam logic [3:0] ST_CCHK  = 4'd5;
    localparam logic [3:0] ST_WRITE = 4'd6;
    localparam logic [3:0] ST_HOUT  = 4'd7;
    localparam logic [3:0] ST_MODQ  = 4'd8;
    localparam logic [3:0] ST_MODR  = 4'd9;

    // storage
    logic [HW-1:0]             m_hdr [SLOTS];
    logic [wvhc_pkg::CP_W-1:0] m_chr [CD];
    logic [wvhc_pkg::CP_W-1:0] m_inc [MAX_LEN];

    logic [3:0]                r_st, n_st;
    logic [31:0]               r_hash, n_hash;
    logic [LW-1:0]             r_len, n_len;
    logic [SW-1:0]             r_home, n_home, r_idx, n_idx, r_tgt, n_tgt;
    logic [SW:0]               r_cnt, n_cnt;
    logic [SW:0]               r_q, n_q;
    logic [LW-1:0]             r_ci, n_ci;
    logic                      r_put, n_put, r_vin, n_vin;
    logic                      r_ov, n_ov, r_sv, n_sv;
    wvhc_pkg::t_out            r_od, n_od, r_sd, n_sd;

    logic [HW-1:0]             r_hq;
    logic [wvhc_pkg::CP_W-1:0] r_cq, r_iq;

    // memory controls
    logic                      hw_en, cw_en, iw_en;
    logic [SW-1:0]             hw_a, hr_a;
    logic [HW-1:0]             hw_d;
    logic [AW-1:0]             cw_a, cr_a;
    logic [wvhc_pkg::CP_W-1:0] cw_d, iw_d;
    logic [CW-1:0]             iw_a, ir_a;

    logic                      acc;
    logic [31:0]               hash_nx;
    logic [AW-1:0]             base_idx, base_tgt;
    logic [SW-1:0]             idx_nx;
    logic                      res_v;
    wvhc_pkg::t_out            res_d;
    logic [64:0]               mq_prod;
    logic [SW:0]               mq_rem;
    logic [SW-1:0]             mq_home;

    assign acc      = i_valid && o_ready;
    assign hash_nx  = (r_hash << 5) + r_hash + 32'(i_data.code_point);
    assign base_idx = AW'(r_idx) * AW'(MAX_LEN);
    assign base_tgt = AW'(r_tgt) * AW'(MAX_LEN);
    assign idx_nx   = (r_idx == SW'(SLOTS - 1)) ? '0 : r_idx + 1'b1;
    assign o_ready  = (r_st == ST_IDLE) && !r_sv;
    assign o_valid  = r_ov;
    assign o_data   = r_od;

    // home slot: quotient estimate, then remainder with one correction step
    assign mq_prod  = 65'(r_hash) * 65'(RECIP);
    assign mq_rem   = r_hash[SW:0] - r_q * (SW+1)'(SLOTS);
    assign mq_home  = (mq_rem >= (SW+1)'(SLOTS)) ? SW'(mq_rem - (SW+1)'(SLOTS)) : SW'(mq_rem);

    // memories: one write and one registered read each
    always_ff @(posedge i_clk) begin
        if (hw_en) m_hdr[hw_a] <= hw_d;
        r_hq <= m_hdr[hr_a];
        if (cw_en) m_chr[cw_a] <= cw_d;
        r_cq <= m_chr[cr_a];
        if (iw_en) m_inc[iw_a] <= iw_d;
        r_iq <= m_inc[ir_a];
    end

    // control
    always_comb begin
        n_st = r_st; n_hash = r_hash; n_len = r_len; n_home = r_home; n_idx = r_idx;
        n_tgt = r_tgt; n_cnt = r_cnt; n_ci = r_ci; n_put = r_put; n_vin = r_vin;
        n_q = r_q;
        n_ov = r_ov; n_od = r_od; n_sv = r_sv; n_sd = r_sd;
        res_v = 1'b0; res_d = '0;
        hw_en = 1'b0; hw_a = r_idx; hw_d = '0; hr_a = r_idx;
        cw_en = 1'b0; cw_a = base_tgt + AW'(r_ci); cw_d = r_iq;
        iw_en = 1'b0; iw_a = r_len[CW-1:0]; iw_d = i_data.code_point;
        cr_a = base_idx + AW'(r_ci); ir_a = r_ci[CW-1:0];
        case (r_st)
            ST_CLR: begin
                hw_en = 1'b1;
                n_idx = idx_nx;
                if (r_idx == SW'(SLOTS - 1)) n_st = ST_IDLE;
            end
            ST_IDLE: begin
                if (acc) begin
                    if (i_data.kind == wvhc_pkg::KIND_CLEAR) begin
                        n_hash = wvhc_pkg::HASH_START; n_len = '0; n_idx = '0;
                        n_st = ST_CLR;
                    end else if (i_data.kind != wvhc_pkg::KIND_RSVD) begin
                        iw_en  = (r_len < LW'(MAX_LEN));
                        n_len  = (r_len <= LW'(MAX_LEN)) ? r_len + 1'b1 : r_len;
                        n_hash = hash_nx;
                        if (i_data.last) begin
                            n_hash = wvhc_pkg::HASH_START;
                            n_len  = '0;
                            n_put  = (i_data.kind == wvhc_pkg::KIND_PUT);
                            n_vin  = i_data.verdict_in;
                            if (r_len >= LW'(MAX_LEN)) begin
                                res_v = 1'b1;
                                res_d = '{hit: 1'b0, verdict_out: 1'b0, too_long: 1'b1};
                            end else begin
                                n_len  = r_len + 1'b1;   // kept for the probe
                                n_hash = hash_nx;        // kept for the home slot
                                n_st   = ST_MODQ;
                            end
                        end
                    end
                end
            end
            ST_MODQ: begin
                n_q  = (SW+1)'(mq_prod >> (32 + SW));
                n_st = ST_MODR;
            end
            ST_MODR: begin
                n_home = mq_home;
                n_idx  = mq_home;
                n_tgt  = mq_home;
                n_cnt  = '0;
                n_st   = ST_HRD;
            end
            ST_HRD: n_st = ST_HCHK;
            ST_HCHK: begin
                n_ci = '0;
                if (!r_hq[HW-1]) begin
                    n_tgt = r_idx;
                    if (r_put) begin n_st = ST_WRITE; end
                    else n_st = ST_HOUT;
                end else if (r_hq[LW-1:0] == r_len) begin
                    n_st = ST_CRD;
                end else if (r_cnt == (SW+1)'(SLOTS - 1)) begin
                    n_tgt = r_home;
                    n_st  = r_put ? ST_WRITE : ST_HOUT;
                end else begin
                    n_cnt = r_cnt + 1'b1; n_idx = idx_nx; n_st = ST_HRD;
                end
                if (n_st == ST_HOUT) begin
                    res_v = 1'b1; res_d = '0; n_st = ST_IDLE;
                end
                if (n_st == ST_WRITE) n_len = r_len;
            end
            ST_CRD: n_st = ST_CCHK;
            ST_CCHK: begin
                if (r_cq != r_iq) begin
                    if (r_cnt == (SW+1)'(SLOTS - 1)) begin
                        n_tgt = r_home;
                        if (r_put) n_st = ST_WRITE;
                        else begin res_v = 1'b1; res_d = '0; n_st = ST_IDLE; end
                        n_ci = '0;
                    end else begin
                        n_cnt = r_cnt + 1'b1; n_idx = idx_nx; n_st = ST_HRD;
                    end
                end else if (r_ci == r_len - 1'b1) begin
                    // full match
                    if (r_put) begin
                        hw_en = 1'b1; hw_a = r_idx; hw_d = {1'b1, r_vin, r_len};
                    end else begin
                        res_v = 1'b1;
                        res_d = '{hit: 1'b1, verdict_out: r_hq[HW-2], too_long: 1'b0};
                    end
                    n_st = ST_IDLE;
                end else begin
                    n_ci = r_ci + 1'b1; n_st = ST_CRD;
                end
            end
            ST_WRITE: begin
                // r_iq holds char r_ci-1 once r_ci is nonzero
                ir_a = r_ci[CW-1:0];
                n_ci = r_ci + 1'b1;
                if (r_ci != '0) begin
                    cw_en = 1'b1; cw_a = base_tgt + AW'(r_ci - 1'b1);
                end
                if (r_ci == r_len) begin
                    hw_en = 1'b1; hw_a = r_tgt; hw_d = {1'b1, r_vin, r_len};
                    n_st = ST_IDLE;
                end
            end
            default: n_st = ST_IDLE;
        endcase
        if (r_st != ST_IDLE && r_st != ST_CLR && n_st == ST_IDLE) begin
            n_len  = '0;
            n_hash = wvhc_pkg::HASH_START;
        end

        // two-entry output buffer: head drives the port, second entry waits behind it
        if (r_ov && i_ready) begin
            n_ov = r_sv; n_od = r_sd; n_sv = 1'b0;
        end
        if (res_v) begin
            if (!n_ov) begin
                n_ov = 1'b1; n_od = res_d;
            end else begin
                n_sv = 1'b1; n_sd = res_d;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_CLR; r_hash <= wvhc_pkg::HASH_START; r_len <= '0;
            r_idx <= '0; r_ov <= 1'b0; r_sv <= 1'b0;
        end else begin
            r_st <= n_st; r_hash <= n_hash; r_len <= n_len; r_idx <= n_idx; r_ov <= n_ov;
            r_sv <= n_sv;
        end
        r_home <= n_home; r_tgt <= n_tgt; r_cnt <= n_cnt; r_ci <= n_ci; r_q <= n_q;
        r_put <= n_put; r_vin <= n_vin; r_od <= n_od; r_sd <= n_sd;
    end

    // a result only appears from idle or a probe step
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_st) != ST_CLR && $past(r_st) != ST_WRITE)
        else $error("result raised from clear or write");
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> r_st == ST_IDLE)
        else $error("ready outside idle");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("pending result lost");

endmodule

@@ verif/tb_word_verdict_hash_cache.sv @@
// Self-checking testbench for word_verdict_hash_cache: lookups, puts, clears, long words.
// Depends on wvhc_pkg and word_verdict_hash_cache; a built-in table predictor checks each result.
`timescale 1ns / 1ps
module tb_word_verdict_hash_cache;

    localparam int SLOTS     = 64;
    localparam int MAX_LEN   = 255;
    localparam int VOCAB     = 90;
    localparam int STALL_MAX = 200000;

    logic           i_clk;
    logic           i_rst_n;
    logic           in_valid;
    logic           in_ready;
    wvhc_pkg::t_in  in_beat;
    logic           out_valid;
    logic           out_ready;
    wvhc_pkg::t_out out_beat;

    word_verdict_hash_cache #(.SLOTS(SLOTS), .MAX_LEN(MAX_LEN)) uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(in_valid), .o_ready(in_ready), .i_data(in_beat),
        .o_valid(out_valid), .i_ready(out_ready), .o_data(out_beat)
    );

    // predicted table contents
    logic        tbl_valid [SLOTS];
    int          tbl_len [SLOTS];
    logic        tbl_verdict [SLOTS];
    logic [20:0] tbl_chars [SLOTS][MAX_LEN];
    logic [20:0] in_chars [MAX_LEN];
    logic [31:0] word_hash;
    int          in_count;

    wvhc_pkg::t_in  beat_q [$];
    wvhc_pkg::t_out verdict_q [$];

    int   send_idle_pct;
    int   recv_stall_pct;
    int   hold_req;
    int   hold_seen;
    int   hold_cnt;
    int   stall_cycles;
    int   errors;
    int   n_in;
    int   n_out;
    int   n_hit;
    int   n_long;
    logic in_fire;

    logic [20:0] vocab_cp [VOCAB][8];
    int          vocab_len [VOCAB];

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // restart the incoming word
    task automatic word_restart();
        word_hash = wvhc_pkg::HASH_START;
        in_count  = 0;
    endtask

    function automatic logic entry_matches(int idx);
        if (tbl_len[idx] != in_count) return 1'b0;
        for (int i = 0; i < in_count; i++)
            if (tbl_chars[idx][i] != in_chars[i]) return 1'b0;
        return 1'b1;
    endfunction

    // apply one accepted beat to the predicted table
    task automatic predict_beat(input wvhc_pkg::t_in b);
        wvhc_pkg::t_out r;
        int   home;
        int   idx;
        int   target;
        logic done;
        r = '0;
        if (b.kind == wvhc_pkg::KIND_RSVD) return;
        if (b.kind == wvhc_pkg::KIND_CLEAR) begin
            for (int i = 0; i < SLOTS; i++) tbl_valid[i] = 1'b0;
            word_restart();
            return;
        end
        if (in_count < MAX_LEN) in_chars[in_count] = b.code_point;
        if (in_count <= MAX_LEN) in_count++;
        word_hash = word_hash * 32'd33 + 32'(b.code_point);
        if (!b.last) return;
        home = int'(word_hash % SLOTS);
        if (in_count > MAX_LEN) begin
            r.too_long = 1'b1;
            verdict_q.push_back(r);
        end else if (b.kind == wvhc_pkg::KIND_LOOKUP) begin
            for (int i = 0; i < SLOTS; i++) begin
                idx = (home + i) % SLOTS;
                if (!tbl_valid[idx]) break;
                if (entry_matches(idx)) begin
                    r.hit = 1'b1;
                    r.verdict_out = tbl_verdict[idx];
                    break;
                end
            end
            verdict_q.push_back(r);
        end else begin
            target = home;
            done = 1'b0;
            for (int i = 0; i < SLOTS; i++) begin
                idx = (home + i) % SLOTS;
                if (!tbl_valid[idx]) begin
                    target = idx;
                    break;
                end
                if (entry_matches(idx)) begin
                    tbl_verdict[idx] = b.verdict_in;
                    done = 1'b1;
                    break;
                end
            end
            if (!done) begin
                for (int i = 0; i < in_count; i++) tbl_chars[target][i] = in_chars[i];
                tbl_len[target] = in_count;
                tbl_verdict[target] = b.verdict_in;
                tbl_valid[target] = 1'b1;
            end
        end
        word_restart();
    endtask

    // queue one word; body beats may carry either character kind
    task automatic queue_word(input logic [1:0] k, input logic v, input logic [20:0] cps[$],
                              input logic mix);
        wvhc_pkg::t_in b;
        for (int i = 0; i < cps.size(); i++) begin
            b.kind = (mix && i != cps.size() - 1) ? 2'($urandom_range(1)) : k;
            b.code_point = cps[i];
            b.last = (i == cps.size() - 1);
            b.verdict_in = (i == cps.size() - 1) ? v : 1'($urandom_range(1));
            beat_q.push_back(b);
        end
    endtask

    task automatic queue_vocab(input int w, input logic [1:0] k, input logic v);
        logic [20:0] cps [$];
        for (int i = 0; i < vocab_len[w]; i++) cps.push_back(vocab_cp[w][i]);
        queue_word(k, v, cps, $urandom_range(9) == 0);
    endtask

    task automatic queue_fresh(input logic [1:0] k, input int n);
        logic [20:0] cps [$];
        for (int i = 0; i < n; i++) cps.push_back(21'($urandom));
        queue_word(k, 1'($urandom_range(1)), cps, 1'b0);
    endtask

    task automatic queue_ctrl(input logic [1:0] k);
        wvhc_pkg::t_in b;
        b.kind = k;
        b.code_point = 21'($urandom);
        b.last = 1'($urandom_range(1));
        b.verdict_in = 1'($urandom_range(1));
        beat_q.push_back(b);
    endtask

    task automatic drain();
        while (beat_q.size() != 0 || in_valid || verdict_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic random_phase(input int n_items);
        int target;
        int pick;
        target = beat_q.size() + n_items;
        while (beat_q.size() < target) begin
            pick = $urandom_range(999);
            if (pick < 450) queue_vocab($urandom_range(VOCAB - 1), wvhc_pkg::KIND_LOOKUP, 1'b0);
            else if (pick < 820) queue_vocab($urandom_range(VOCAB - 1), wvhc_pkg::KIND_PUT,
                                             1'($urandom_range(1)));
            else if (pick < 930) queue_fresh(2'($urandom_range(1)), $urandom_range(1, 6));
            else if (pick < 955) queue_ctrl(wvhc_pkg::KIND_CLEAR);
            else if (pick < 975) queue_ctrl(wvhc_pkg::KIND_RSVD);
            else if (pick < 977) queue_fresh(2'($urandom_range(1)), $urandom_range(256, 258));
            else if (pick < 979) queue_fresh(2'($urandom_range(1)), MAX_LEN);
            else queue_fresh(wvhc_pkg::KIND_LOOKUP, $urandom_range(1, 3));
        end
    endtask

    // sender: new beat only once the previous one is taken
    always @(negedge i_clk) begin
        if (!in_valid || in_fire) begin
            if (i_rst_n && beat_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                in_beat  <= beat_q.pop_front();
                in_valid <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // receiver: random stalls plus a requested long hold-off
    always @(negedge i_clk) begin
        if (hold_cnt > 0) begin
            hold_cnt  <= hold_cnt - 1;
            out_ready <= 1'b0;
        end else if (hold_seen != hold_req) begin
            hold_seen <= hold_req;
            hold_cnt  <= 3000;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // input beats feed the predictor; result beats are checked in order
    always @(posedge i_clk) begin
        in_fire = in_valid && in_ready && i_rst_n;
        if (in_fire) begin
            n_in++;
            predict_beat(in_beat);
        end
        if (i_rst_n && out_valid && out_ready) begin
            n_out++;
            if (verdict_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result hit=%b verdict=%b too_long=%b", $time,
                         out_beat.hit, out_beat.verdict_out, out_beat.too_long);
            end else begin
                if (verdict_q[0].hit) n_hit++;
                if (verdict_q[0].too_long) n_long++;
                if (out_beat.hit !== verdict_q[0].hit)
                    $display("%0t: hit expected %b actual %b", $time,
                             verdict_q[0].hit, out_beat.hit);
                if (out_beat.verdict_out !== verdict_q[0].verdict_out)
                    $display("%0t: verdict_out expected %b actual %b", $time,
                             verdict_q[0].verdict_out, out_beat.verdict_out);
                if (out_beat.too_long !== verdict_q[0].too_long)
                    $display("%0t: too_long expected %b actual %b", $time,
                             verdict_q[0].too_long, out_beat.too_long);
                if (out_beat !== verdict_q[0]) errors++;
                void'(verdict_q.pop_front());
            end
        end
        if (in_fire || (out_valid && out_ready)) stall_cycles = 0;
        else stall_cycles++;
        if (stall_cycles >= STALL_MAX) begin
            $display("%0t: no progress for %0d cycles", $time, STALL_MAX);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        logic [20:0] w [$];
        in_valid = 1'b0;
        in_beat = '0;
        out_ready = 1'b0;
        i_rst_n = 1'b0;
        in_fire = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_req = 0;
        hold_seen = 0;
        hold_cnt = 0;
        stall_cycles = 0;
        errors = 0;
        n_in = 0;
        n_out = 0;
        n_hit = 0;
        n_long = 0;
        for (int i = 0; i < SLOTS; i++) begin
            tbl_valid[i] = 1'b0;
            tbl_len[i] = 0;
            tbl_verdict[i] = 1'b0;
        end
        word_restart();
        // short words, a few with wide code points
        for (int i = 0; i < VOCAB; i++) begin
            vocab_len[i] = $urandom_range(1, 6);
            for (int j = 0; j < 8; j++)
                vocab_cp[i][j] = ($urandom_range(3) == 0) ? 21'($urandom)
                                                          : 21'($urandom_range(97, 122));
        end
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: empty lookup, put, hit, update, extremes, clear, reserved kind
        queue_vocab(0, wvhc_pkg::KIND_LOOKUP, 1'b0);
        w = '{21'h000000, 21'h1FFFFF};
        queue_word(wvhc_pkg::KIND_PUT, 1'b1, w, 1'b0);
        queue_word(wvhc_pkg::KIND_LOOKUP, 1'b0, w, 1'b0);
        queue_word(wvhc_pkg::KIND_PUT, 1'b0, w, 1'b0);
        queue_word(wvhc_pkg::KIND_LOOKUP, 1'b1, w, 1'b0);
        w = '{21'h1FFFFF, 21'h000000, 21'h0AAAAA};
        queue_word(wvhc_pkg::KIND_PUT, 1'b1, w, 1'b1);
        queue_word(wvhc_pkg::KIND_LOOKUP, 1'b0, w, 1'b1);
        queue_ctrl(wvhc_pkg::KIND_RSVD);
        w = '{21'h155555, 21'h000001};
        queue_word(wvhc_pkg::KIND_PUT, 1'b1, w, 1'b0);
        w = '{21'h155555};
        queue_word(wvhc_pkg::KIND_LOOKUP, 1'b0, w, 1'b0);
        queue_fresh(wvhc_pkg::KIND_LOOKUP, 1);
        beat_q.push_back(wvhc_pkg::t_in'{wvhc_pkg::KIND_LOOKUP, 21'h12345, 1'b0, 1'b0});
        queue_ctrl(wvhc_pkg::KIND_CLEAR);
        w = '{21'h000000, 21'h1FFFFF};
        queue_word(wvhc_pkg::KIND_LOOKUP, 1'b0, w, 1'b0);
        drain();

        // random phases with different idling; the first one holds off the receiver
        hold_req = 1;
        random_phase(450);
        drain();
        send_idle_pct = 84;
        random_phase(300);
        drain();
        send_idle_pct = 0;
        recv_stall_pct = 84;
        random_phase(400);
        drain();
        send_idle_pct = 27;
        recv_stall_pct = 27;
        random_phase(400);
        drain();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        random_phase(200);
        drain();
        repeat (17000) @(posedge i_clk);

        $display("beats in %0d, results %0d (hits %0d, too long %0d)", n_in, n_out, n_hit,
                 n_long);
        $display("covered lookups, puts, updates, full probe circles, clears, long words");
        if (errors == 0 && verdict_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0d mismatches, %0d results missing", errors, verdict_q.size());
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule

@@ word_verdict_hash_cache.f @@
rtl/wvhc_pkg.sv
rtl/word_verdict_hash_cache.sv
verif/tb_word_verdict_hash_cache.sv
